// ----- sv/u8dec_pkg.sv -----
// ----------------------------------------------------------------------------
// u8dec_pkg: shared types and constants of the UTF-8 stream decoder
// Result kinds, lead byte tags and the per-byte step result record.
// ----------------------------------------------------------------------------
package u8dec_pkg;

  localparam int CpWidth   = 21;
  localparam int KindWidth = 2;
  localparam int PendWidth = 2;

  // result kinds
  localparam logic [KindWidth-1:0] KIND_CHAR  = 2'd0;
  localparam logic [KindWidth-1:0] KIND_END   = 2'd1;
  localparam logic [KindWidth-1:0] KIND_ERROR = 2'd2;

  // lead and continuation byte tags (upper bits of the byte)
  localparam logic [1:0] CONT_TAG  = 2'h2;   // 10xxxxxx
  localparam logic [2:0] LEAD2_TAG = 3'h6;   // 110xxxxx
  localparam logic [3:0] LEAD3_TAG = 4'hE;   // 1110xxxx
  localparam logic [4:0] LEAD4_TAG = 5'h1E;  // 11110xxx

  typedef struct packed {
    logic                 has_result;
    logic [CpWidth-1:0]   code_point;
    logic [KindWidth-1:0] kind;
    logic [PendWidth-1:0] pending_next;
    logic [CpWidth-1:0]   partial_next;
  } step_res_t;

endpackage

// ----- sv/u8dec_step.sv -----
// ----------------------------------------------------------------------------
// u8dec_step: one byte of decode
// Combines the held byte with the decoder state into the next state and an
// optional result.
// ----------------------------------------------------------------------------
module u8dec_step (
  input  logic [7:0]                     in_byte,
  input  logic [u8dec_pkg::PendWidth-1:0] pending,
  input  logic [u8dec_pkg::CpWidth-1:0]   partial,
  output u8dec_pkg::step_res_t           res
);
  import u8dec_pkg::*;

  logic [CpWidth-1:0] shifted;

  assign shifted = {partial[CpWidth-7:0], in_byte[5:0]};

  always_comb begin
    res.has_result   = 1'b0;
    res.code_point   = '0;
    res.kind         = KIND_CHAR;
    res.pending_next = '0;
    res.partial_next = '0;
    if (pending != '0) begin
      if (in_byte[7:6] == CONT_TAG) begin
        if (pending == PendWidth'(1)) begin
          res.has_result = 1'b1;
          res.code_point = shifted;
          res.kind       = KIND_CHAR;
        end else begin
          res.pending_next = pending - PendWidth'(1);
          res.partial_next = shifted;
        end
      end else begin
        // drop the offending byte and report the broken sequence
        res.has_result = 1'b1;
        res.kind       = KIND_ERROR;
      end
    end else if (in_byte == 8'h00) begin
      res.has_result = 1'b1;
      res.kind       = KIND_END;
    end else if (in_byte[7] == 1'b0) begin
      res.has_result = 1'b1;
      res.code_point = CpWidth'(in_byte);
      res.kind       = KIND_CHAR;
    end else if (in_byte[7:5] == LEAD2_TAG) begin
      res.pending_next = PendWidth'(1);
      res.partial_next = CpWidth'(in_byte[4:0]);
    end else if (in_byte[7:4] == LEAD3_TAG) begin
      res.pending_next = PendWidth'(2);
      res.partial_next = CpWidth'(in_byte[3:0]);
    end else if (in_byte[7:3] == LEAD4_TAG) begin
      res.pending_next = PendWidth'(3);
      res.partial_next = CpWidth'(in_byte[2:0]);
    end else begin
      // stray continuation or bad lead byte
      res.has_result = 1'b1;
      res.kind       = KIND_ERROR;
    end
  end

endmodule

// ----- sv/utf8_stream_decoder_core.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core: byte-serial UTF-8 decoder
// Input byte register, combinational decode step, registered result.
// ----------------------------------------------------------------------------
// The decoder takes one byte per item and returns at most one result item per
// byte: a code point when a 1 to 4 byte character completes (kind 0), an
// end-of-string mark for a zero byte seen while idle (kind 1), or an error
// for a stray continuation byte, a bad lead byte or a missing continuation
// (kind 2); end and error results carry code point zero. The byte that
// breaks a sequence is consumed, and the decoder returns to idle. Overlong
// forms and surrogates are not checked. Throughput is one byte per clock
// unless a result waits for room; the decode of a byte is one short step
// between the input and result registers, and the pending count and
// partial code point update in that same cycle. A result is loaded as the
// input register releases its byte, when the result register has room. A
// byte that yields no result keeps moving even while the result register is
// stalled; only a byte that yields a result waits for room.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [u8dec_pkg::CpWidth-1:0]   code_point,
  output logic [u8dec_pkg::KindWidth-1:0] kind
);
  import u8dec_pkg::*;

  // input register
  logic       held_valid;
  logic [7:0] held_byte;

  // decoder state
  logic [PendWidth-1:0] pending;
  logic [CpWidth-1:0]   partial;

  step_res_t res;
  logic      out_free;
  logic      advance;

  u8dec_step u_step (
    .in_byte (held_byte),
    .pending (pending),
    .partial (partial),
    .res     (res)
  );

  // The result register has room when empty or being drained this cycle.
  assign out_free = !out_valid || !out_stall;
  // Advance the held byte unless its result has nowhere to go.
  assign advance  = held_valid && (!res.has_result || out_free);
  // Hold the input side only while the held byte cannot advance.
  assign in_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_byte <= in_byte;
    end
  end

  // Update the decoder state as each byte leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      partial <= '0;
    end else if (advance) begin
      pending <= res.pending_next;
      partial <= res.partial_next;
    end
  end

  // Result register: load a new result, or drop the one just taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.has_result) begin
      code_point <= res.code_point;
      kind       <= res.kind;
    end
  end

endmodule
